### src/ffrn_pkg.sv
// shared types and constants for the flat-field reference normalizer
// no dependencies
package ffrn_pkg;

   localparam int MaxBands   = 32;
   localparam int MaxWidth   = 2048;
   localparam int SampleBits = 16;
   localparam int BandBits   = 5;
   localparam int ColBits    = 11;
   localparam int AddrBits   = BandBits + ColBits;
   localparam int SumBits    = 24;
   localparam int Depth      = MaxBands * MaxWidth;
   localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

   typedef enum logic [1:0] {
      CMD_WHITE = 2'd0,
      CMD_BLACK = 2'd1,
      CMD_NORM  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_WHITE_LINES = 2'd0,
      REG_BLACK_LINES = 2'd1,
      REG_BANDS       = 2'd2,
      REG_WIDTH       = 2'd3
   } reg_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, start store read
      logic clr_step;   // write zero at sweep address
      logic wb;         // write back updated sums
      logic div_start;  // start the average divisions
      logic qdiv_start; // start the quotient division
      logic finish;     // form the result into the output register
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic qdiv_done;
      logic is_norm;
      logic ok;
      logic winv;
   } sts_type;

endpackage

### src/flat_field_reference_normalizer_core.sv
// top level of the flat-field reference normalizer
// depends on ffrn_pkg, ffrn_ctrl, ffrn_datapath
//
// channel  dir  payload
// req_     in   tdata: command[1:0] band[6:2] column[17:7] sample[33:18]
// rsp_     out  tdata: normalized[31:0]; tuser: saturated, reference_invalid, index_error
// csr_     in   index[1:0], data[11:0]
//
// add and clear requests pass through accept with store read, then write back
// a normalize request runs 32 steps of the average dividers
// then 48 steps of the quotient divider, one bit per cycle each
// a zero white average skips the quotient divider, an index error both dividers
// after reset a clearing pass over all 65536 addresses zeroes both stores, no request taken
// the result waits in an output register; the next request is taken meanwhile
module flat_field_reference_normalizer_core import ffrn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // command, band, column, sample, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // normalized
   output logic [2:0]  rsp_tuser,  // saturated, reference_invalid, index_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   logic [8:0]  white_lines_ff, black_lines_ff;
   logic [5:0]  bands_ff;
   logic [11:0] width_ff;
   ctl_type     ctl;
   sts_type     sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         white_lines_ff <= 9'd1;
         black_lines_ff <= 9'd1;
         bands_ff       <= 6'd1;
         width_ff       <= 12'd2048;
      end else if (csr_valid) begin
         unique case (reg_type'(csr_index))
            REG_WHITE_LINES: white_lines_ff <= csr_data[8:0];
            REG_BLACK_LINES: black_lines_ff <= csr_data[8:0];
            REG_BANDS:       bands_ff       <= csr_data[5:0];
            REG_WIDTH:       width_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   ffrn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   ffrn_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .req_cmd     (req_tdata[1:0]),
      .req_band    (req_tdata[6:2]),
      .req_col     (req_tdata[17:7]),
      .req_sample  (req_tdata[33:18]),
      .white_lines (white_lines_ff),
      .black_lines (black_lines_ff),
      .bands       (bands_ff),
      .width       (width_ff),
      .res_norm    (rsp_tdata),
      .res_sat     (rsp_tuser[0]),
      .res_inv     (rsp_tuser[1]),
      .res_idx     (rsp_tuser[2])
   );

endmodule

### src/ffrn_datapath.sv
// reference stores, average and quotient dividers, saturation
// depends on ffrn_pkg
module ffrn_datapath import ffrn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   output sts_type              sts,
   input  logic [1:0]           req_cmd,
   input  logic [BandBits-1:0]  req_band,
   input  logic [ColBits-1:0]   req_col,
   input  logic [15:0]          req_sample,
   input  logic [8:0]           white_lines,
   input  logic [8:0]           black_lines,
   input  logic [5:0]           bands,
   input  logic [11:0]          width,
   output logic [31:0]          res_norm,
   output logic                 res_sat,
   output logic                 res_inv,
   output logic                 res_idx
);

   logic [SumBits-1:0] white_mem [Depth];
   logic [SumBits-1:0] black_mem [Depth];

   logic [1:0]           cmd_ff;
   logic [AddrBits-1:0]  addr_ff;
   logic [SampleBits-1:0] x_ff;
   logic                 ok_ff;
   logic [SumBits-1:0]   wrd_ff, brd_ff;
   logic [AddrBits:0]    clr_ff;
   logic                 ok_in;
   logic [6:0]           nb;
   logic [12:0]          nw;

   assign nb = (bands > 6'(MaxBands)) ? 7'(MaxBands) : {1'b0, bands};
   assign nw = (width > 12'(MaxWidth)) ? 13'(MaxWidth) : {1'b0, width};
   assign ok_in = ({2'b0, req_band} < nb) && ({2'b0, req_col} < nw);

   // store access: read on load, write back or clear sweep
   logic [SumBits-1:0] wnew, bnew;
   logic [SumBits:0]   wadd, badd;
   assign wadd = {1'b0, wrd_ff} + (SumBits+1)'(x_ff);
   assign badd = {1'b0, brd_ff} + (SumBits+1)'(x_ff);

   always_comb begin
      wnew = wrd_ff;
      bnew = brd_ff;
      case (cmd_ff)
         CMD_WHITE: wnew = wadd[SumBits] ? SumMax : wadd[SumBits-1:0];
         CMD_BLACK: bnew = badd[SumBits] ? SumMax : badd[SumBits-1:0];
         CMD_CLEAR: begin
            wnew = '0;
            bnew = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.clr_step) begin
         white_mem[clr_ff[AddrBits-1:0]] <= '0;
         black_mem[clr_ff[AddrBits-1:0]] <= '0;
      end else if (ctl.wb && ok_ff) begin
         white_mem[addr_ff] <= wnew;
         black_mem[addr_ff] <= bnew;
      end
      if (ctl.load) begin
         wrd_ff <= white_mem[{req_band, req_col}];
         brd_ff <= black_mem[{req_band, req_col}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.clr_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         addr_ff <= {req_band, req_col};
         x_ff    <= req_sample[SampleBits-1:0];
         ok_ff   <= ok_in;
      end
   end

   // two restoring dividers for the averages: (sum<<8)/count, 32 steps
   localparam int AvgBits = SumBits + 8;
   logic [AvgBits-1:0] wq_ff, bq_ff;
   logic [9:0]         wr_ff, br_ff;
   logic [8:0]         wc_ff, bc_ff;
   logic [5:0]         acnt_ff;
   logic               abusy_ff, adone_ff;
   logic [9:0]         wtr, btr;
   logic [10:0]        wdf, bdf;

   assign wtr = {wr_ff[8:0], wq_ff[AvgBits-1]};
   assign btr = {br_ff[8:0], bq_ff[AvgBits-1]};
   assign wdf = {1'b0, wtr} - {2'b0, wc_ff};
   assign bdf = {1'b0, btr} - {2'b0, bc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         abusy_ff <= 1'b0;
         adone_ff <= 1'b0;
      end else begin
         adone_ff <= 1'b0;
         if (ctl.div_start) begin
            abusy_ff <= 1'b1;
         end else if (abusy_ff && acnt_ff == 6'(AvgBits - 1)) begin
            abusy_ff <= 1'b0;
            adone_ff <= 1'b1;
         end
      end
      if (ctl.div_start) begin
         wq_ff   <= {wrd_ff, 8'd0};
         bq_ff   <= {brd_ff, 8'd0};
         wr_ff   <= '0;
         br_ff   <= '0;
         wc_ff   <= (white_lines == '0) ? 9'd1 : white_lines;
         bc_ff   <= (black_lines == '0) ? 9'd1 : black_lines;
         acnt_ff <= '0;
      end else if (abusy_ff) begin
         acnt_ff <= acnt_ff + 1'b1;
         if (!wdf[10]) begin
            wr_ff <= wdf[9:0];
            wq_ff <= {wq_ff[AvgBits-2:0], 1'b1};
         end else begin
            wr_ff <= wtr;
            wq_ff <= {wq_ff[AvgBits-2:0], 1'b0};
         end
         if (!bdf[10]) begin
            br_ff <= bdf[9:0];
            bq_ff <= {bq_ff[AvgBits-2:0], 1'b1};
         end else begin
            br_ff <= btr;
            bq_ff <= {bq_ff[AvgBits-2:0], 1'b0};
         end
      end
   end

   // quotient: |diff|<<16 / wavg, restoring, 48 steps; sign applied after
   localparam int DiffBits = AvgBits + 1;
   localparam int NumBits  = AvgBits + 16;
   logic [DiffBits-1:0] diff;
   logic                neg_ff;
   logic [NumBits-1:0]  qq_ff;
   logic [AvgBits:0]    qr_ff;
   logic [AvgBits-1:0]  qd_ff;
   logic [5:0]          qcnt_ff;
   logic                qbusy_ff, qdone_ff;
   logic [AvgBits:0]    qtr;
   logic [AvgBits+1:0]  qdf;
   logic [AvgBits-1:0]  mag;

   assign diff = {9'd0, x_ff, 8'd0} - {1'b0, bq_ff};
   assign mag  = diff[DiffBits-1] ? AvgBits'(-diff) : diff[AvgBits-1:0];
   assign qtr  = {qr_ff[AvgBits-1:0], qq_ff[NumBits-1]};
   assign qdf  = {1'b0, qtr} - {2'b0, qd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         qbusy_ff <= 1'b0;
         qdone_ff <= 1'b0;
      end else begin
         qdone_ff <= 1'b0;
         if (ctl.qdiv_start) begin
            qbusy_ff <= 1'b1;
         end else if (qbusy_ff && qcnt_ff == 6'(NumBits - 1)) begin
            qbusy_ff <= 1'b0;
            qdone_ff <= 1'b1;
         end
      end
      if (ctl.qdiv_start) begin
         qq_ff   <= {mag, 16'd0};
         qr_ff   <= '0;
         qd_ff   <= wq_ff;
         neg_ff  <= diff[DiffBits-1];
         qcnt_ff <= '0;
      end else if (qbusy_ff) begin
         qcnt_ff <= qcnt_ff + 1'b1;
         if (!qdf[AvgBits+1]) begin
            qr_ff <= qdf[AvgBits:0];
            qq_ff <= {qq_ff[NumBits-2:0], 1'b1};
         end else begin
            qr_ff <= qtr;
            qq_ff <= {qq_ff[NumBits-2:0], 1'b0};
         end
      end
   end

   // saturation of the signed quotient
   logic pos_big, neg_big, winv;
   assign winv    = (wq_ff == '0);
   assign pos_big = !neg_ff && (qq_ff[NumBits-1:31] != '0);
   assign neg_big = neg_ff && ((qq_ff[NumBits-1:32] != '0)
                    || (qq_ff[31] && qq_ff[30:0] != '0));

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         res_idx <= !ok_ff;
         res_inv <= ok_ff && winv;
         if (!ok_ff) begin
            res_norm <= '0;
            res_sat  <= 1'b0;
         end else if (winv) begin
            res_norm <= diff[DiffBits-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            res_sat  <= 1'b1;
         end else if (pos_big) begin
            res_norm <= 32'h7FFF_FFFF;
            res_sat  <= 1'b1;
         end else if (neg_big) begin
            res_norm <= 32'h8000_0000;
            res_sat  <= 1'b1;
         end else begin
            res_norm <= neg_ff ? 32'(-qq_ff[31:0]) : qq_ff[31:0];
            res_sat  <= 1'b0;
         end
      end
   end

   assign sts.clr_last  = (clr_ff == (AddrBits+1)'(Depth - 1));
   assign sts.div_done  = adone_ff;
   assign sts.qdiv_done = qdone_ff;
   assign sts.is_norm   = (cmd_ff == CMD_NORM);
   assign sts.ok        = ok_ff;
   assign sts.winv      = winv;

endmodule

### src/ffrn_ctrl.sv
// sequencer: clearing sweep, read, update or divide, result handoff
// depends on ffrn_pkg
module ffrn_ctrl import ffrn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_AVG, ST_QUOT, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;

   always_comb begin
      state_in = state_ff;
      rv_in    = rv_ff;
      ctl      = '0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!sts.is_norm) begin
               ctl.wb   = 1'b1;
               state_in = ST_IDLE;
            end else if (!sts.ok) begin
               state_in = ST_FIN;
            end else begin
               ctl.div_start = 1'b1;
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (sts.div_done) begin
               if (sts.winv) begin
                  state_in = ST_FIN;
               end else begin
                  ctl.qdiv_start = 1'b1;
                  state_in = ST_QUOT;
               end
            end
         end
         ST_QUOT: begin
            if (sts.qdiv_done) state_in = ST_FIN;
         end
         ST_FIN: begin
            // output register must be free
            if (!rv_ff || rsp_tready) begin
               ctl.finish = 1'b1;
               rv_in      = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_tvalid = rv_ff;

endmodule

### tb/tb_flat_field_reference_normalizer_core.sv
// self-checking bench for flat_field_reference_normalizer_core: directed and random
// requests with an internal prediction of the white/black sums and the Q15.16 quotient
// depends on ffrn_pkg and the core rtl
module tb_flat_field_reference_normalizer_core;
   import ffrn_pkg::*;

   localparam int IdleLimit = 200000;

   typedef struct {
      cmd_type     cmd;
      logic [4:0]  band;
      logic [10:0] col;
      logic [15:0] x;
   } request_type;

   typedef struct {
      logic [31:0] norm;
      logic        sat;
      logic        inval;
      logic        idx_err;
   } flat_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   request_type     pending_reqs[$];
   flat_result_type expected_results[$];
   request_type     cur_req;
   logic [23:0]  white_acc[0:Depth-1];
   logic [23:0]  black_acc[0:Depth-1];
   int unsigned  white_lines = 1, black_lines = 1, band_limit = 1, col_limit = 2048;
   int           err_count = 0;
   int           req_gap = 0, rsp_stall = 0, idle_cnt = 0;
   bit           idling_on = 1'b1;

   flat_field_reference_normalizer_core u_top (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report(string what);
      $display("mismatch: %s", what);
      err_count++;
   endtask

   function automatic longint avg_q8(logic [23:0] acc, int unsigned lines);
      longint c;
      c = (lines == 0) ? 1 : lines;
      return (longint'(acc) * 256) / c;
   endfunction

   // sum that sticks at the top instead of wrapping
   function automatic logic [23:0] sum_add(logic [23:0] acc, logic [15:0] x);
      logic [24:0] s;
      s = {1'b0, acc} + {9'd0, x};
      return s[24] ? SumMax : s[23:0];
   endfunction

   // update the sums and queue the result a normalize request should give
   function automatic void flat_field_predict(request_type r);
      int unsigned  nb, nw, idx;
      bit           ok;
      longint       wavg, bavg, diff, q;
      flat_result_type res;
      nb  = (band_limit > MaxBands) ? MaxBands : band_limit;
      nw  = (col_limit > MaxWidth) ? MaxWidth : col_limit;
      ok  = (r.band < nb) && (r.col < nw);
      idx = {r.band, r.col};
      res = '{norm: '0, sat: 1'b0, inval: 1'b0, idx_err: 1'b0};
      if (r.cmd != CMD_NORM) begin
         if (ok) begin
            case (r.cmd)
               CMD_WHITE: white_acc[idx] = sum_add(white_acc[idx], r.x);
               CMD_BLACK: black_acc[idx] = sum_add(black_acc[idx], r.x);
               default: begin
                  white_acc[idx] = '0;
                  black_acc[idx] = '0;
               end
            endcase
         end
         return;
      end
      if (!ok) begin
         res.idx_err = 1'b1;
      end else begin
         wavg = avg_q8(white_acc[idx], white_lines);
         bavg = avg_q8(black_acc[idx], black_lines);
         diff = longint'(r.x) * 256 - bavg;
         if (wavg == 0) begin
            res.inval = 1'b1;
            res.sat   = 1'b1;
            q = (diff >= 0) ? 64'sd2147483647 : -64'sd2147483648;
         end else begin
            q = (diff * 65536) / wavg;
            if (q > 64'sd2147483647) begin
               q = 64'sd2147483647;
               res.sat = 1'b1;
            end else if (q < -64'sd2147483648) begin
               q = -64'sd2147483648;
               res.sat = 1'b1;
            end
         end
         res.norm = q[31:0];
      end
      expected_results.push_back(res);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) flat_field_predict(cur_req);
         if (req_tvalid && !req_tready) begin
            // hold the request until taken
         end else if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_tdata  <= {6'b0, cur_req.x, cur_req.col, cur_req.band, cur_req.cmd};
            req_tvalid <= 1'b1;
            req_gap    <= idling_on ? $urandom_range(0, 7) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      flat_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report($sformatf("unexpected result %h/%b", rsp_tdata, rsp_tuser));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.norm)
                  report($sformatf("normalized %h, want %h", rsp_tdata, want.norm));
               if (rsp_tuser[0] !== want.sat)
                  report($sformatf("saturated %b, want %b", rsp_tuser[0], want.sat));
               if (rsp_tuser[1] !== want.inval)
                  report($sformatf("reference_invalid %b, want %b", rsp_tuser[1], want.inval));
               if (rsp_tuser[2] !== want.idx_err)
                  report($sformatf("index_error %b, want %b", rsp_tuser[2], want.idx_err));
            end
            rsp_stall  <= idling_on ? $urandom_range(0, 7) : 0;
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cnt <= 0;
      end else if (idle_cnt >= IdleLimit) begin
         $display("tb_flat_field_reference_normalizer_core: done, errors");
         $finish;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
   end

   task automatic write_reg(reg_type r, logic [11:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (r)
         REG_WHITE_LINES: white_lines = 32'(v & 12'h1FF);
         REG_BLACK_LINES: black_lines = 32'(v & 12'h1FF);
         REG_BANDS:       band_limit  = 32'(v & 12'h03F);
         default:         col_limit   = 32'(v);
      endcase
   endtask

   task automatic configure(int wl, int bl, int nb, int nw);
      write_reg(REG_WHITE_LINES, 12'(wl));
      write_reg(REG_BLACK_LINES, 12'(bl));
      write_reg(REG_BANDS, 12'(nb));
      write_reg(REG_WIDTH, 12'(nw));
   endtask

   task automatic push(cmd_type c, int b, int col, int x);
      pending_reqs.push_back('{cmd: c, band: 5'(b), col: 11'(col), x: 16'(x)});
   endtask

   // wait for all traffic to settle, then let in-flight adds finish
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   initial begin
      int cfg[6][4];
      int pool_b[4], pool_c[4];
      int nb, nw, k, sel;
      cfg = '{'{1, 1, 32, 2048}, '{256, 256, 32, 2048}, '{0, 0, 8, 64},
              '{7, 3, 63, 4095}, '{100, 5, 0, 16}, '{3, 200, 17, 1}};
      for (int i = 0; i < Depth; i++) begin
         white_acc[i] = '0;
         black_acc[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty references, extremes, sum overflow
      configure(1, 1, 32, 2048);
      push(CMD_NORM, 0, 0, 0);
      push(CMD_BLACK, 0, 0, 65535);
      push(CMD_NORM, 0, 0, 0);
      push(CMD_WHITE, 31, 2047, 65535);
      push(CMD_NORM, 31, 2047, 65535);
      push(CMD_NORM, 31, 2047, 0);
      push(CMD_WHITE, 1, 5, 1);
      push(CMD_NORM, 1, 5, 65535);
      push(CMD_CLEAR, 31, 2047, 0);
      push(CMD_NORM, 31, 2047, 100);
      for (int i = 0; i < 260; i++) push(CMD_WHITE, 2, 3, 65535);
      push(CMD_NORM, 2, 3, 65535);
      drain();
      configure(2, 3, 4, 100);
      push(CMD_WHITE, 5, 0, 77);
      push(CMD_NORM, 5, 0, 1);
      push(CMD_NORM, 0, 100, 1);
      push(CMD_CLEAR, 4, 99, 0);
      push(CMD_WHITE, 3, 99, 1000);
      push(CMD_NORM, 3, 99, 40000);
      drain();

      // random phases over several settings
      for (int p = 0; p < 6; p++) begin
         configure(cfg[p][0], cfg[p][1], cfg[p][2], cfg[p][3]);
         idling_on = (p % 3) != 2;
         nb = (cfg[p][2] > MaxBands) ? MaxBands : ((cfg[p][2] == 0) ? 1 : cfg[p][2]);
         nw = (cfg[p][3] > MaxWidth) ? MaxWidth : cfg[p][3];
         for (int i = 0; i < 4; i++) begin
            pool_b[i] = $urandom_range(0, nb - 1);
            pool_c[i] = $urandom_range(0, nw - 1);
         end
         for (int i = 0; i < 270; i++) begin
            request_type r;
            k   = $urandom_range(0, 99);
            sel = $urandom_range(0, 3);
            r.cmd = (k < 30) ? CMD_WHITE : (k < 55) ? CMD_BLACK : (k < 92) ? CMD_NORM
                    : CMD_CLEAR;
            if ($urandom_range(0, 99) < 85) begin
               r.band = 5'(pool_b[sel]);
               r.col  = 11'(pool_c[sel]);
            end else begin
               r.band = 5'($urandom_range(0, 31));
               r.col  = 11'($urandom_range(0, 2047));
            end
            r.x = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 65535))
                  : 16'($urandom_range(0, 300));
            pending_reqs.push_back(r);
         end
         drain();
      end

      if (err_count == 0) begin
         $display("tb_flat_field_reference_normalizer_core: done, clean");
      end else begin
         $display("tb_flat_field_reference_normalizer_core: done, errors");
      end
      $finish;
   end

endmodule
